// ----- hdl/c3pf_pkg.sv -----
// Shared types and register codes for the 3x3 convolution pixel filter.
package c3pf_pkg;

  localparam int PIXEL_W  = 8;
  localparam int COEF_W   = 8;
  localparam int TAPS     = 9;
  localparam int PROD_W   = 17;
  localparam int SUM_W    = 21;
  localparam int RESULT_W = 20;
  localparam int POS_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int ROWREG_W = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_BOTTOM = 3'd4;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] filtered_value;
    logic [POS_W-1:0]           center_col;
    logic [POS_W-1:0]           center_row;
    logic                       frame_last;
  } out_item_t;

endpackage

// ----- hdl/conv3x3_pixel_filter.sv -----
// 3x3 convolution over a raster pixel stream with two line stores and a window.
//
// Accepts one pixel per clock while the output is not stalled, and gives at most one result per pixel: the
// exact signed weighted sum of the 3x3 neighborhood for every interior position,
// with its center column and row. An accepted pixel is registered with its line-store
// reads, then its nine products are registered, and then their sum is registered in the
// output register. An output stall backs up through these stages to in_stall. The line
// stores start undefined and need no clearing pass; the block takes pixels from the
// first cycle after reset.
// Configuration writes are always ready and are meant to be issued while idle.
module conv3x3_pixel_filter
  import c3pf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROWREG_W-1:0]  cfg_data
);

  localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int EW0 = (WW > SIZE_W) ? WW : SIZE_W;
  localparam int EW  = ((HW > EW0) ? HW : EW0) + 1;

  // configuration registers
  logic [SIZE_W-1:0]   image_width;
  logic [SIZE_W-1:0]   image_height;
  logic [ROWREG_W-1:0] coef_row [3];

  // position counters
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  // line stores
  logic [PIXEL_W-1:0] line_store_upper [MAX_WIDTH];
  logic [PIXEL_W-1:0] line_store_lower [MAX_WIDTH];

  logic [PIXEL_W-1:0] win [6];

  // stage 1: store read data
  logic               s1_valid;
  logic [CW-1:0]      s1_col;
  logic [RW-1:0]      s1_row;
  logic [PIXEL_W-1:0] s1_pixel;
  logic               s1_interior;
  logic               s1_last;
  logic [PIXEL_W-1:0] rd_upper;
  logic [PIXEL_W-1:0] rd_lower;
  logic               s1_fwd;
  logic [PIXEL_W-1:0] fwd_upper;
  logic [PIXEL_W-1:0] fwd_lower;

  // stage 2: products
  logic                     s2_valid;
  logic                     s2_emit;
  logic [POS_W-1:0]         s2_col;
  logic [POS_W-1:0]         s2_row;
  logic                     s2_last;
  logic signed [PROD_W-1:0] prod [TAPS];

  logic in_accept;
  logic s1_adv;
  logic s2_go;
  logic ready2;
  logic ready3;

  logic [EW-1:0]        w_raw;
  logic [EW-1:0]        h_raw;
  logic [EW-1:0]        w_eff;
  logic [EW-1:0]        h_eff;
  logic [CW-1:0]        col_start;
  logic [RW-1:0]        row_start;
  logic [CW-1:0]        col_cur;
  logic [RW-1:0]        row_cur;
  logic [CW-1:0]        col_count_next;
  logic [RW-1:0]        row_count_next;
  logic                 cur_interior;
  logic                 cur_last;
  logic [PIXEL_W-1:0]   cur [3];
  logic [PIXEL_W-1:0]   tap [TAPS];
  logic signed [SUM_W-1:0] sum;
  logic [EW-1:0]        center_col_wide;
  logic [EW-1:0]        center_row_wide;

  assign cfg_ready = 1'b1;

  assign ready3    = !out_valid || !out_stall;
  assign s2_go     = s2_valid && (!s2_emit || ready3);
  assign ready2    = !s2_valid || s2_go;
  assign s1_adv    = s1_valid && ready2;
  assign in_stall  = s1_valid && !ready2;
  assign in_accept = in_valid && !in_stall;

  // effective frame size, clamped to 3..MAX
  always_comb begin
    w_raw = EW'(image_width);
    h_raw = EW'(image_height);
    if (w_raw < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < EW'(3)) begin
      h_eff = EW'(3);
    end else if (h_raw > EW'(MAX_HEIGHT)) begin
      h_eff = EW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // position of the incoming pixel and the counters after it
  always_comb begin
    col_start = in_data.frame_start ? '0 : col_count;
    row_start = in_data.frame_start ? '0 : row_count;
    col_cur   = (EW'(col_start) >= w_eff) ? '0 : col_start;
    row_cur   = (EW'(row_start) >= h_eff) ? '0 : row_start;
    cur_interior = (EW'(col_cur) >= EW'(2)) && (EW'(row_cur) >= EW'(2));
    cur_last = (EW'(col_cur) == w_eff - EW'(1)) && (EW'(row_cur) == h_eff - EW'(1));
    if (EW'(col_cur) + EW'(1) >= w_eff) begin
      col_count_next = '0;
      row_count_next = (EW'(row_cur) + EW'(1) >= h_eff) ? '0 : row_cur + RW'(1);
    end else begin
      col_count_next = col_cur + CW'(1);
      row_count_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(640);
      image_height <= SIZE_W'(480);
      coef_row[0]  <= '0;
      coef_row[1]  <= '0;
      coef_row[2]  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:     image_width  <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT:    image_height <= cfg_data[SIZE_W-1:0];
        CFG_COEF_ROW_TOP:    coef_row[0]  <= cfg_data;
        CFG_COEF_ROW_MIDDLE: coef_row[1]  <= cfg_data;
        CFG_COEF_ROW_BOTTOM: coef_row[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // window column in use: forward the write that landed on the same entry as this read
  always_comb begin
    cur[0] = s1_fwd ? fwd_upper : rd_upper;
    cur[1] = s1_fwd ? fwd_lower : rd_lower;
    cur[2] = s1_pixel;
  end

  // line stores: read on request, write back when the column leaves stage 1
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_upper <= line_store_upper[col_cur];
      rd_lower <= line_store_lower[col_cur];
    end
    if (s1_adv) begin
      line_store_upper[s1_col] <= cur[1];
      line_store_lower[s1_col] <= cur[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col      <= col_cur;
      s1_row      <= row_cur;
      s1_pixel    <= in_data.pixel;
      s1_interior <= cur_interior;
      s1_last     <= cur_last;
      s1_fwd      <= s1_adv && (s1_col == col_cur);
      fwd_upper   <= cur[1];
      fwd_lower   <= cur[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int v = 0; v < 3; v++) begin
        win[2*v]   <= win[2*v+1];
        win[2*v+1] <= cur[v];
      end
    end
  end

  // taps in mask order: row by row, left to right
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      tap[3*v]   = win[2*v];
      tap[3*v+1] = win[2*v+1];
      tap[3*v+2] = cur[v];
    end
  end

  always_comb begin
    center_col_wide = EW'(s1_col) - EW'(1);
    center_row_wide = EW'(s1_row) - EW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_emit <= s1_interior;
      s2_col  <= center_col_wide[POS_W-1:0];
      s2_row  <= center_row_wide[POS_W-1:0];
      s2_last <= s1_last;
      for (int v = 0; v < 3; v++) begin
        for (int k = 0; k < 3; k++) begin
          prod[3*v+k] <= $signed({{(PROD_W-PIXEL_W){1'b0}}, tap[3*v+k]})
                       * $signed({{(PROD_W-COEF_W){coef_row[v][COEF_W*k+COEF_W-1]}},
                                  coef_row[v][COEF_W*k +: COEF_W]});
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + SUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s2_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_emit) begin
      out_data.filtered_value <= sum[RESULT_W-1:0];
      out_data.center_col     <= s2_col;
      out_data.center_row     <= s2_row;
      out_data.frame_last     <= s2_last;
    end
  end

  // a request is taken only when stage 1 is free or moving on
  assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (!s1_valid || s1_adv))
    else $error("pixel taken while stage 1 is blocked");

  // a frame start places its pixel at column 0 of row 0
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.frame_start) |=> (col_count == CW'(1) && row_count == '0))
    else $error("frame start did not restart the position counters");

  // a result that cannot leave stays in the product stage
  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_emit && !ready3) |=> (s2_valid && s2_emit))
    else $error("blocked result dropped from product stage");

  // the result register changes only when free or taken
  assert property (@(posedge clk) disable iff (rst)
    (s2_go && s2_emit) |-> ready3)
    else $error("result register overwritten while stalled");

endmodule
